// ===== hw/rtl/tlrte_pkg.sv =====
// shared types and constants for the text line reader with tab expansion
package tlrte_pkg;

    localparam int TAB_STOP_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 8;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] BYTE_EOF   = 8'd26;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_THORN = 8'hFE;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    localparam logic [15:0] COL_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    localparam logic CFG_EOF_MODE  = 1'b0;
    localparam logic CFG_KEEP_TABS = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_EOL    = 2'd1,
        OP_EOF    = 2'd2,
        OP_SPACES = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic [15:0]      len;
        logic [15:0]      num;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

endpackage

// ===== hw/rtl/text_line_reader_tab_expand.sv =====
// Text line reader with tab expansion, top level. The front end takes one
// byte per cycle (stall only while the command queue of QUEUE_DEPTH entries
// is full) and updates column, line count and end-of-file state at once;
// the output sequencer sends one result beat per cycle while out_stall is
// low. A byte gives at most one command, and every command is one beat
// except an expanded tab, which is up to eight space beats, so the
// sustained rate is one byte per cycle except while tab spaces go out. An
// accepted byte passes through the command queue and then the registered
// output stage. Carriage returns, restart beats and bytes after end of
// file produce no result. Configuration writes are always ready.
module text_line_reader_tab_expand
    import tlrte_pkg::*;
#(
    parameter int TAB_STOP    = TAB_STOP_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        restart,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic [1:0]  kind,
    output logic [15:0] line_length,
    output logic [15:0] line_number,
    output logic        last
);

    logic push, q_full, q_empty, pop;
    cmd_t push_cmd, pop_cmd;

    tlrte_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .restart   (restart),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tlrte_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tlrte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_cmd       (pop_cmd),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .kind        (kind),
        .line_length (line_length),
        .line_number (line_number),
        .last        (last)
    );

endmodule

// ===== hw/rtl/tlrte_front.sv =====
// front end: accepts bytes, keeps line state and classifies each byte into a command
module tlrte_front
    import tlrte_pkg::*;
#(
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       restart,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int PH_W   = $clog2(TAB_STOP);
    localparam int DIST_W = $clog2(TAB_STOP + 1);
    localparam int SUM_W  = (DIST_W > CNT_W) ? DIST_W : CNT_W;
    localparam logic [PH_W-1:0] SAT_PHASE = PH_W'(32'hFFFF % TAB_STOP);
    localparam logic [PH_W-1:0] PH_LAST   = PH_W'(TAB_STOP - 1);

    logic             eof_mode_reg, eof_mode_next;
    logic             keep_tabs_reg, keep_tabs_next;
    logic [15:0]      column_reg, column_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [15:0]      line_count_reg, line_count_next;
    logic             thorn_seen_reg, thorn_seen_next;
    logic             file_ended_reg, file_ended_next;

    logic             accept;
    logic [SUM_W-1:0] tab_gap;
    logic             capped;
    logic [CNT_W-1:0] tab_cnt;
    logic [16:0]      tab_sum;
    logic [15:0]      line_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign line_inc  = line_count_reg + 16'd1;

    // spaces up to the next tab stop, capped at the result limit
    assign tab_gap = SUM_W'(TAB_STOP) - SUM_W'(phase_reg);
    assign capped  = tab_gap > SUM_W'(MAX_RESULTS);
    assign tab_cnt = capped ? CNT_W'(MAX_RESULTS) : CNT_W'(tab_gap);
    assign tab_sum = {1'b0, column_reg} + 17'(tab_cnt);

    always_comb
    begin
        eof_mode_next   = eof_mode_reg;
        keep_tabs_next  = keep_tabs_reg;
        column_next     = column_reg;
        phase_next      = phase_reg;
        line_count_next = line_count_reg;
        thorn_seen_next = thorn_seen_reg;
        file_ended_next = file_ended_reg;
        push            = 1'b0;
        push_cmd        = '{op: OP_CHAR, ch: byte_in, len: 16'd0, num: 16'd0,
                            cnt: '0};

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_EOF_MODE)
                eof_mode_next = cfg_data;
            else
                keep_tabs_next = cfg_data;
        end

        if (accept)
        begin
            if (restart)
            begin
                column_next     = '0;
                phase_next      = '0;
                line_count_next = '0;
                thorn_seen_next = 1'b0;
                file_ended_next = 1'b0;
            end
            else if (!file_ended_reg)
            begin
                if (byte_in == BYTE_EOF)
                begin
                    push            = 1'b1;
                    push_cmd        = '{op: OP_EOF, ch: 8'd0, len: column_reg,
                                        num: line_count_reg, cnt: '0};
                    file_ended_next = 1'b1;
                end
                else if (byte_in == BYTE_THORN && eof_mode_reg && thorn_seen_reg)
                begin
                    push            = 1'b1;
                    push_cmd        = '{op: OP_EOF, ch: 8'd0, len: column_reg - 16'd1,
                                        num: line_count_reg, cnt: '0};
                    file_ended_next = 1'b1;
                end
                else if (byte_in == BYTE_LF)
                begin
                    push            = 1'b1;
                    push_cmd        = '{op: OP_EOL, ch: 8'd0, len: column_reg,
                                        num: line_inc, cnt: '0};
                    line_count_next = line_inc;
                    column_next     = '0;
                    phase_next      = '0;
                    thorn_seen_next = 1'b0;
                end
                else if (byte_in == BYTE_CR)
                begin
                    push = 1'b0;
                end
                else if (byte_in == BYTE_TAB && !keep_tabs_reg)
                begin
                    push     = 1'b1;
                    push_cmd = '{op: OP_SPACES, ch: BYTE_SPACE, len: 16'd0,
                                 num: 16'd0, cnt: tab_cnt};
                    if (tab_sum >= {1'b0, COL_MAX})
                    begin
                        column_next = COL_MAX;
                        phase_next  = SAT_PHASE;
                    end
                    else
                    begin
                        column_next = tab_sum[15:0];
                        // a capped run stops short of the tab stop
                        phase_next  = capped ?
                                      PH_W'(SUM_W'(phase_reg) + SUM_W'(MAX_RESULTS)) : '0;
                    end
                end
                else
                begin
                    if (byte_in == BYTE_THORN && eof_mode_reg)
                        thorn_seen_next = 1'b1;
                    push = 1'b1;
                    if (column_reg != COL_MAX)
                    begin
                        column_next = column_reg + 16'd1;
                        phase_next  = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_mode_reg   <= 1'b0;
            keep_tabs_reg  <= 1'b0;
            column_reg     <= '0;
            phase_reg      <= '0;
            line_count_reg <= '0;
            thorn_seen_reg <= 1'b0;
            file_ended_reg <= 1'b0;
        end
        else
        begin
            eof_mode_reg   <= eof_mode_next;
            keep_tabs_reg  <= keep_tabs_next;
            column_reg     <= column_next;
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            thorn_seen_reg <= thorn_seen_next;
            file_ended_reg <= file_ended_next;
        end
    end

endmodule

// ===== hw/rtl/tlrte_queue.sv =====
// command queue between the front end and the output sequencer
module tlrte_queue
    import tlrte_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = fill_reg == CNT_QW'(QUEUE_DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/tlrte_back.sv =====
// output sequencer: turns commands into result beats, one per cycle while out_stall is low
module tlrte_back
    import tlrte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        q_cmd,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic [1:0]  kind,
    output logic [15:0] line_length,
    output logic [15:0] line_number,
    output logic        last
);

    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic [1:0]       kind_reg, kind_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      num_reg, num_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             load;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = 1'b0;
            if (rem_reg != '0)
            begin
                // rest of a tab run
                valid_next = 1'b1;
                char_next  = BYTE_SPACE;
                kind_next  = KIND_CHAR;
                len_next   = '0;
                num_next   = '0;
                last_next  = rem_reg == CNT_W'(1);
                rem_next   = rem_reg - 1'b1;
            end
            else if (!q_empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                char_next  = q_cmd.ch;
                len_next   = q_cmd.len;
                num_next   = q_cmd.num;
                last_next  = 1'b1;
                case (q_cmd.op)
                    OP_CHAR:   kind_next = KIND_CHAR;
                    OP_EOL:    kind_next = KIND_EOL;
                    OP_EOF:    kind_next = KIND_EOF;
                    OP_SPACES:
                    begin
                        kind_next = KIND_CHAR;
                        last_next = q_cmd.cnt == CNT_W'(1);
                        rem_next  = q_cmd.cnt - 1'b1;
                    end
                    default:   kind_next = KIND_CHAR;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        kind_reg <= kind_next;
        len_reg  <= len_next;
        num_reg  <= num_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign char_out    = char_reg;
    assign kind        = kind_reg;
    assign line_length = len_reg;
    assign line_number = num_reg;
    assign last        = last_reg;

endmodule

// ===== sim/text_line_reader_tab_expand_tb.sv =====
// testbench for the text line reader: directed and random text checks
`timescale 1ns / 100ps

module text_line_reader_tab_expand_tb;
    import tlrte_pkg::*;

    localparam int TAB_W        = TAB_STOP_DEF;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic [7:0]  ch;
        logic [1:0]  kind;
        logic [15:0] len;
        logic [15:0] num;
        logic        last;
    } reader_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_in     = 8'd0;
    logic        restart     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_index   = 1'b0;
    logic        cfg_data    = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  char_out;
    logic [1:0]  kind;
    logic [15:0] line_length;
    logic [15:0] line_number;
    logic        last;

    // expected output of the reader, oldest first
    reader_beat_t expected_beats[$];
    reader_beat_t want_beat;

    // mirrored reader state and registers
    logic [15:0] col_pos       = 16'd0;
    logic [15:0] lines_done    = 16'd0;
    logic        thorn_pending = 1'b0;
    logic        eof_reached   = 1'b0;
    logic        mode_eof      = 1'b0;
    logic        mode_keep_tab = 1'b0;

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  tx_gaps     = 1'b0;
    bit  rx_gaps     = 1'b0;

    text_line_reader_tab_expand DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .restart     (restart),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .kind        (kind),
        .line_length (line_length),
        .line_number (line_number),
        .last        (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, expected_beats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic void push_beat(input logic [7:0] ch, input logic [1:0] k,
                                      input logic [15:0] len, input logic [15:0] num,
                                      input logic lst);
        reader_beat_t bt;
        bt.ch   = ch;
        bt.kind = k;
        bt.len  = len;
        bt.num  = num;
        bt.last = lst;
        expected_beats.push_back(bt);
    endfunction

    function automatic void bump_column();
        if (col_pos != COL_MAX)
            col_pos = col_pos + 16'd1;
    endfunction

    // works out the beats one accepted input byte causes and updates the mirror
    function automatic void predict_reader_output(input logic [7:0] b, input logic rs);
        int n_sp;
        if (rs)
        begin
            col_pos       = 16'd0;
            lines_done    = 16'd0;
            thorn_pending = 1'b0;
            eof_reached   = 1'b0;
            return;
        end
        if (eof_reached)
            return;
        if (b == BYTE_EOF)
        begin
            push_beat(8'd0, KIND_EOF, col_pos, lines_done, 1'b1);
            eof_reached = 1'b1;
        end
        else if (b == BYTE_THORN && mode_eof && thorn_pending)
        begin
            push_beat(8'd0, KIND_EOF, col_pos - 16'd1, lines_done, 1'b1);
            eof_reached = 1'b1;
        end
        else if (b == BYTE_LF)
        begin
            lines_done = lines_done + 16'd1;
            push_beat(8'd0, KIND_EOL, col_pos, lines_done, 1'b1);
            col_pos       = 16'd0;
            thorn_pending = 1'b0;
        end
        else if (b == BYTE_CR)
        begin
            return;
        end
        else if (b == BYTE_TAB && !mode_keep_tab)
        begin
            n_sp = TAB_W - (col_pos % TAB_W);
            if (n_sp > MAX_RESULTS)
                n_sp = MAX_RESULTS;
            for (int i = 0; i < n_sp; i++)
            begin
                push_beat(BYTE_SPACE, KIND_CHAR, 16'd0, 16'd0, i == n_sp - 1);
                bump_column();
            end
        end
        else
        begin
            if (b == BYTE_THORN && mode_eof)
                thorn_pending = 1'b1;
            push_beat(b, KIND_CHAR, 16'd0, 16'd0, 1'b1);
            bump_column();
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat kind=%0d char=%02h",
                                          kind, char_out));
            else
            begin
                want_beat = expected_beats.pop_front();
                if (char_out !== want_beat.ch)
                    report_mismatch($sformatf("char_out %02h, want %02h",
                                              char_out, want_beat.ch));
                if (kind !== want_beat.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want_beat.kind));
                if (line_length !== want_beat.len)
                    report_mismatch($sformatf("line_length %0d, want %0d",
                                              line_length, want_beat.len));
                if (line_number !== want_beat.num)
                    report_mismatch($sformatf("line_number %0d, want %0d",
                                              line_number, want_beat.num));
                if (last !== want_beat.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want_beat.last));
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (rx_gaps && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        if (tx_gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall);
        predict_reader_output(b, rs);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_EOF_MODE)
            mode_eof = val;
        else
            mode_keep_tab = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_modes(input logic eof_m, input logic keep_t);
        wait_results_done();
        write_reg(CFG_EOF_MODE, eof_m);
        write_reg(CFG_KEEP_TABS, keep_t);
    endtask

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 8'($urandom_range(32, 126));
        else if (r < 63) return BYTE_TAB;
        else if (r < 71) return BYTE_LF;
        else if (r < 75) return BYTE_CR;
        else if (r < 81) return BYTE_THORN;
        else if (r < 84) return BYTE_EOF;
        else             return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        set_modes(1'b0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(BYTE_TAB, 1'b0);     // partial tab stop
        send_byte(BYTE_TAB, 1'b0);     // full tab stop
        send_byte(BYTE_CR, 1'b0);
        send_byte(BYTE_THORN, 1'b0);   // plain characters in mode 0
        send_byte(BYTE_THORN, 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte(BYTE_TAB, 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(BYTE_EOF, 1'b0);
        send_byte(8'h43, 1'b0);        // ignored after end of file
        send_byte(BYTE_LF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h45, 1'b0);
        send_byte(BYTE_EOF, 1'b1);     // restart wins over the byte
        send_byte(BYTE_LF, 1'b0);
        set_modes(1'b1, 1'b1);
        send_byte(BYTE_TAB, 1'b0);     // kept as is
        send_byte(BYTE_THORN, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(BYTE_THORN, 1'b0);   // second thorn ends the file
        send_byte(8'h00, 1'b1);
        send_byte(BYTE_THORN, 1'b0);
        send_byte(BYTE_LF, 1'b0);      // line end clears the thorn
        send_byte(BYTE_THORN, 1'b0);
        send_byte(BYTE_EOF, 1'b0);     // end of file at nonzero column
    endtask

    task automatic test_random_text();
        int n_items;
        logic fe_before;
        logic rs;
        logic [7:0] b;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_modes(ph[0], ph[1]);
            tx_gaps = 1'b1;
            rx_gaps = 1'b1;
            n_items = 0;
            while (n_items < 45)
            begin
                if (ph == 1 && n_items == 22)
                    wait_results_done();
                if (ph == 3 && n_items == 12)
                begin
                    tx_gaps = 1'b0;
                    rx_gaps = 1'b0;
                end
                fe_before = eof_reached;
                rs = fe_before ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 49) == 0);
                b  = rs ? 8'($urandom_range(0, 255)) : pick_text_byte();
                send_byte(b, rs);
                if (!fe_before || rs)
                    n_items++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_directed();
        test_random_text();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        wait_results_done();
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
